// ----- sv/sacl_pkg.sv -----
// shared types and constants for the set associative cache controller
package sacl_pkg;
  localparam int SETS = 256;
  localparam int WAYS = 4;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MEM_CYCLES = 100;
  localparam int CYC_W = 18;
  localparam int QDEPTH = 2;

  localparam logic [1:0] CFG_OFFSET = 2'd0;
  localparam logic [1:0] CFG_INDEX  = 2'd1;
  localparam logic [1:0] CFG_WALLOC = 2'd2;
  localparam logic [1:0] CFG_WBACK  = 2'd3;

  // classified access handed from front to back
  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [31:0]      tag;
    logic             store;
    logic [CYC_W-1:0] fill;
  } req_t;

  typedef struct packed {
    logic hit;
    logic dirty_eviction;
    logic [CYC_W-1:0] cycles;
  } res_t;
endpackage

// ----- sv/sacl_front.sv -----
// front end: address split into set and tag, fill cost, two-entry queue to the back end
module sacl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        address,
  input  logic               action,
  input  logic [3:0]         blk_log2,
  input  logic [3:0]         set_log2,
  output logic               q_valid,
  input  logic               q_ready,
  output sacl_pkg::req_t     q_data
);
  import sacl_pkg::*;
  req_t q_r [QDEPTH];
  logic [$clog2(QDEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic wr_ptr_r, rd_ptr_r;
  logic [3:0] off;
  logic [4:0] sh;
  logic [31:0] idx_full;
  req_t req;

  always_comb begin
    off = (blk_log2 < 4'd2) ? 4'd2 : ((blk_log2 > 4'd12) ? 4'd12 : blk_log2);
    sh = {1'b0, off} + {1'b0, set_log2};
    idx_full = (address >> off) & ((32'd1 << set_log2) - 32'd1);
    req.set = idx_full[SET_W-1:0];
    req.tag = (sh > 5'd31) ? 32'd0 : (address >> sh);
    req.store = action;
    req.fill = CYC_W'((32'd1 << (off - 4'd2)) * MEM_CYCLES);
  end

  assign in_ready = (cnt_r != QDEPTH[$clog2(QDEPTH+1)-1:0]);
  assign q_valid = (cnt_r != '0);
  assign q_data = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready && !(q_valid && q_ready)) cnt_nxt = cnt_r + 1'b1;
    else if (!(in_valid && in_ready) && q_valid && q_ready) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_valid && in_ready) wr_ptr_r <= ~wr_ptr_r;
      if (q_valid && q_ready) rd_ptr_r <= ~rd_ptr_r;
    end
    if (in_valid && in_ready) q_r[wr_ptr_r] <= req;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QDEPTH) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == QDEPTH |-> !in_ready) else $error("accept while full");
endmodule

// ----- sv/sacl_back.sv -----
// back end: clearing pass after reset, way lookup, lru victim choice, line update and cost
module sacl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  sacl_pkg::req_t q_data,
  input  logic           write_allocate,
  input  logic           write_back,
  output logic           res_valid,
  input  logic           res_ready,
  output sacl_pkg::res_t res_data
);
  import sacl_pkg::*;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;
  // line word from the top bit down: valid, dirty, tag, stamp
  localparam int LINE_W = 1 + 1 + 32 + 32;

  logic [2:0] state_r, state_nxt;
  logic [LINE_W-1:0] mem [SETS][WAYS];
  logic [LINE_W-1:0] rd_r [WAYS];
  logic [SET_W-1:0] clr_set_r;
  logic [31:0] counter_r;
  req_t req_r;
  res_t res_r;
  logic hit;
  logic [WAY_W-1:0] hit_way, victim, inv_way, lru_way;
  logic any_inv;
  logic [31:0] best;
  logic do_alloc, ev_dirty;
  logic [CYC_W-1:0] cyc, extra;
  logic [WAY_W-1:0] upd_way;
  logic do_upd;
  logic [LINE_W-1:0] new_line;

  always_comb begin
    hit = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
    lru_way = '0; best = rd_r[0][31:0];
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && rd_r[w][65] && rd_r[w][63:32] == req_r.tag) begin
        hit = 1'b1; hit_way = WAY_W'(w);
      end
      if (!any_inv && !rd_r[w][65]) begin
        any_inv = 1'b1; inv_way = WAY_W'(w);
      end
      if (w > 0 && rd_r[w][31:0] < best) begin
        best = rd_r[w][31:0]; lru_way = WAY_W'(w);
      end
    end
    victim = any_inv ? inv_way : lru_way;
    do_alloc = !hit && !(req_r.store && !write_allocate);
    ev_dirty = do_alloc && !any_inv && write_back && rd_r[victim][64];
    extra = ev_dirty ? req_r.fill : '0;
    if (!req_r.store) cyc = hit ? CYC_W'(1) : CYC_W'(1) + req_r.fill + extra;
    else if (hit) cyc = write_back ? CYC_W'(1) : CYC_W'(1 + MEM_CYCLES);
    else if (!write_allocate) cyc = CYC_W'(MEM_CYCLES);
    else if (!write_back) cyc = CYC_W'(1 + MEM_CYCLES) + req_r.fill + extra;
    else cyc = CYC_W'(2) + req_r.fill + extra;
    upd_way = hit ? hit_way : victim;
    do_upd = hit || do_alloc;
    // a hit keeps its tag and dirty mark, a refill starts clean unless a write-back store
    if (hit)
      new_line = {1'b1, rd_r[hit_way][64] | (req_r.store & write_back),
                  rd_r[hit_way][63:32], counter_r + 32'd1};
    else
      new_line = {1'b1, write_back & req_r.store, req_r.tag, counter_r + 32'd1};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_set_r == SET_W'(SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (q_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_OUT;
      ST_OUT:  if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign q_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_OUT);
  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_set_r <= '0;
      counter_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_set_r <= clr_set_r + 1'b1;
      if (state_r == ST_EXEC) counter_r <= counter_r + 32'd1;
    end
    if (q_valid && q_ready) req_r <= q_data;
    // clearing pass: one set per cycle after reset
    if (state_r == ST_CLR) begin
      for (int w = 0; w < WAYS; w++) mem[clr_set_r][w] <= '0;
    end
    if (state_r == ST_READ) begin
      for (int w = 0; w < WAYS; w++) rd_r[w] <= mem[req_r.set][w];
    end
    if (state_r == ST_EXEC) begin
      res_r.hit <= hit;
      res_r.dirty_eviction <= ev_dirty;
      res_r.cycles <= cyc;
      if (do_upd) mem[req_r.set][upd_way] <= new_line;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> !res_valid) else $error("ready while result pending");
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> res_valid) else $error("result not presented");
  a_counter: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == ST_EXEC && state_r == ST_OUT |-> counter_r == $past(counter_r) + 32'd1)
    else $error("counter not advanced");
endmodule

// ----- sv/set_assoc_cache_lru_controller_top.sv -----
// top level of the set associative lru cache controller
// an access passes through the queue, then the read, compare and output states of the back end
// the back end takes a new access only once the result of the last one has been taken
// a two-beat queue lets the front take beats while the back end is busy
// reset (rst_n low, synchronous) sets counter and config to defaults and starts a clearing pass
// clearing pass wipes all 256 sets, one set per cycle, with the back end held off meanwhile
module set_assoc_cache_lru_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // address
  input  logic        in_tuser,   // action: 0 load, 1 store
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // hit, dirty_eviction, cycles[17:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import sacl_pkg::*;
  logic [3:0] blk_log2_r, set_log2_r;
  logic write_allocate_r, write_back_r;
  logic q_valid, q_ready;
  req_t q_data;
  res_t res;

  // config is always accepted
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_log2_r <= 4'd4;
      set_log2_r <= 4'd8;
      write_allocate_r <= 1'b1;
      write_back_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OFFSET: blk_log2_r <= cfg_data;
        CFG_INDEX:  set_log2_r <= cfg_data;
        CFG_WALLOC: write_allocate_r <= cfg_data[0];
        CFG_WBACK:  write_back_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sacl_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .address(in_tdata), .action(in_tuser),
    .blk_log2(blk_log2_r), .set_log2(set_log2_r),
    .q_valid, .q_ready, .q_data
  );

  sacl_back u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .write_allocate(write_allocate_r), .write_back(write_back_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(res)
  );

  // result packing, hit in the lowest bit
  assign out_tdata = {4'd0, res.cycles, res.dirty_eviction, res.hit};
endmodule

// ----- tb/sacl_checker.sv -----
// checker for the cache controller: predicts each access and compares result beats
`timescale 1ns / 1ps
module sacl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_beat,
  input  logic [31:0] in_addr,
  input  logic        in_store,
  input  logic        out_beat,
  input  logic [23:0] out_word,
  input  logic        cfg_beat,
  input  logic [1:0]  cfg_idx,
  input  logic [3:0]  cfg_val,
  output int          fail_count,
  output int          pending
);
  import sacl_pkg::*;
  localparam int LINES = SETS * WAYS;

  logic [31:0] tag_mem [LINES];
  logic        vld_mem [LINES];
  logic        drt_mem [LINES];
  logic [31:0] stamp_mem [LINES];
  logic [31:0] use_count;
  logic [3:0]  off_reg, idx_reg;
  logic        walloc, wback;
  res_t        result_q [$];

  function automatic res_t model_access(logic [31:0] addr, logic store);
    res_t r;
    int off, ib, base, victim, l;
    logic [31:0] fill, extra, cyc;
    logic [63:0] a64, setno;
    logic [31:0] tg;
    logic hit, ev;
    off = (off_reg < 4'd2) ? 2 : ((off_reg > 4'd12) ? 12 : int'(off_reg));
    ib = int'(idx_reg);
    fill = ((32'd1 << off) / 32'd4) * 32'(MEM_CYCLES);
    a64 = {32'd0, addr};
    setno = (a64 >> off) & ((64'd1 << ib) - 64'd1);
    tg = 32'(a64 >> (ib + off));
    hit = 1'b0; ev = 1'b0; extra = '0; victim = -1;
    use_count = use_count + 32'd1;
    base = int'(setno % 64'(SETS)) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      l = base + w;
      if (!hit && vld_mem[l] && tag_mem[l] == tg) begin
        stamp_mem[l] = use_count;
        if (store && wback) drt_mem[l] = 1'b1;
        hit = 1'b1;
      end
    end
    if (!hit && !(store && !walloc)) begin
      for (int w = WAYS - 1; w >= 0; w--)
        if (!vld_mem[base + w]) victim = w;
      if (victim < 0) begin
        victim = 0;
        for (int w = 1; w < WAYS; w++)
          if (stamp_mem[base + w] < stamp_mem[base + victim]) victim = w;
        if (wback && drt_mem[base + victim]) begin
          ev = 1'b1;
          extra = fill;
        end
      end
      l = base + victim;
      vld_mem[l] = 1'b1;
      tag_mem[l] = tg;
      stamp_mem[l] = use_count;
      drt_mem[l] = wback && store;
    end
    if (!store) cyc = hit ? 32'd1 : 32'd1 + fill + extra;
    else if (hit) cyc = wback ? 32'd1 : 32'd1 + 32'(MEM_CYCLES);
    else if (!walloc) cyc = 32'(MEM_CYCLES);
    else if (!wback) cyc = 32'd1 + fill + 32'(MEM_CYCLES) + extra;
    else cyc = 32'd1 + fill + extra + 32'd1;
    r.hit = hit;
    r.dirty_eviction = ev;
    r.cycles = cyc[CYC_W-1:0];
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    res_t exp_r, got;
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        tag_mem[i] = '0; vld_mem[i] = 1'b0; drt_mem[i] = 1'b0; stamp_mem[i] = '0;
      end
      use_count = '0;
      off_reg = 4'd4; idx_reg = 4'd8; walloc = 1'b1; wback = 1'b1;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (cfg_beat)
        case (cfg_idx)
          CFG_OFFSET: off_reg = cfg_val;
          CFG_INDEX:  idx_reg = cfg_val;
          CFG_WALLOC: walloc = cfg_val[0];
          CFG_WBACK:  wback = cfg_val[0];
        endcase
      if (out_beat) begin
        got.hit = out_word[0];
        got.dirty_eviction = out_word[1];
        got.cycles = out_word[19:2];
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", out_word);
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp hit %b dev %b cyc %0d, got hit %b dev %b cyc %0d",
                       exp_r.hit, exp_r.dirty_eviction, exp_r.cycles,
                       got.hit, got.dirty_eviction, got.cycles);
          end
        end
      end
      if (in_beat) result_q.push_back(model_access(in_addr, in_store));
    end
  end
endmodule

// ----- tb/tb_set_assoc_cache_lru_controller_top.sv -----
// stimulus and verdict for the cache controller testbench
`timescale 1ns / 1ps
module tb_set_assoc_cache_lru_controller_top;
  import sacl_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = 0;   // address
  logic        in_tuser = 0;   // action: 0 load, 1 store
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;      // hit, dirty_eviction, cycles[17:0], zero pad
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [3:0]  cfg_data = 0;
  int          fail_count, pending;
  int          cycle_no = 0;
  // stall pattern of the receiver, changes per phase
  int          stall_mode = 0;
  // small pool of 16 hot addresses so that hits and evictions happen often
  logic [31:0] hot_addr [16];

  localparam int LIMIT = 400000;

  always #5 clk = ~clk;

  set_assoc_cache_lru_controller_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sacl_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_beat(in_tvalid && in_tready), .in_addr(in_tdata), .in_store(in_tuser),
    .out_beat(out_tvalid && out_tready), .out_word(out_tdata),
    .cfg_beat(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver back-pressure: free running, randomly stalled, stalled in bursts, or mostly stalled
  always @(posedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ((cycle_no % 16) < 11);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > LIMIT) begin
      $display("tb_set_assoc_cache_lru_controller_top: errors");
      $finish;
    end
  end

  // one register write beat; valid is dropped by the caller once the last one is taken
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // one access beat; valid stays high into the next beat of a burst
  task automatic send_access(logic [31:0] addr, logic store);
    in_tvalid <= 1'b1; in_tdata <= addr; in_tuser <= store;
    do @(posedge clk); while (!in_tready);
  endtask

  // sender gap between bursts
  task automatic maybe_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_mode(logic [3:0] ob, logic [3:0] ib, logic wa, logic wb);
    write_reg(CFG_OFFSET, ob);
    write_reg(CFG_INDEX, ib);
    write_reg(CFG_WALLOC, {3'd0, wa});
    write_reg(CFG_WBACK, {3'd0, wb});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic [31:0] a;
    for (int k = 0; k < 16; k++) hot_addr[k] = $urandom();
    for (int i = 0; i < n; i++) begin
      // mostly reuse a hot address with a random low part, sometimes fully random
      if ($urandom_range(0, 4) != 0)
        a = hot_addr[4'($urandom_range(0, 15))] ^ ($urandom() & 32'hff);
      else
        a = $urandom();
      send_access(a, 1'($urandom_range(0, 1)));
      maybe_gap();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part at reset settings: fill, hits, dirty eviction
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0004, 1'b1);
    send_access(32'hffff_ffff, 1'b1);
    send_access(32'h0001_0000, 1'b0);
    send_access(32'h0002_0000, 1'b1);
    send_access(32'h0003_0000, 1'b0);
    send_access(32'h0004_0000, 1'b0);   // set full, evicts lru (dirty)
    send_access(32'h0005_0000, 1'b1);
    send_access(32'h0000_0000, 1'b0);
    drain();

    // offset out of range low and high, index beyond set count
    set_mode(4'd0, 4'd15, 1'b1, 1'b1);
    send_access(32'h8000_0003, 1'b1);
    send_access(32'h8000_0003, 1'b0);
    send_access(32'h7fff_fffc, 1'b0);
    drain();
    set_mode(4'd15, 4'd0, 1'b1, 1'b0);  // write-through, dirty lines left behind
    send_access(32'h0000_1000, 1'b1);
    send_access(32'h0000_1000, 1'b1);
    send_access(32'hffff_f000, 1'b0);
    send_access(32'h1234_5000, 1'b0);
    send_access(32'h0bad_0000, 1'b0);
    drain();
    set_mode(4'd2, 4'd8, 1'b0, 1'b0);   // no-write-allocate
    send_access(32'h0000_0040, 1'b1);
    send_access(32'h0000_0040, 1'b0);
    send_access(32'h0000_0040, 1'b1);
    drain();
    set_mode(4'd12, 4'd2, 1'b0, 1'b1);  // unsupported mix, still predicted
    send_access(32'h0000_3000, 1'b0);
    send_access(32'h0000_3000, 1'b1);
    send_access(32'h0010_3000, 1'b1);
    drain();

    // random phases over several settings and receiver patterns
    for (int p = 0; p < 12; p++) begin
      stall_mode = p % 4;
      case (p % 6)
        0: set_mode(4'd4, 4'd8, 1'b1, 1'b1);
        1: set_mode(4'd2, 4'd1, 1'b1, 1'b1);
        2: set_mode(4'd12, 4'd0, 1'b1, 1'b0);
        3: set_mode(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1, 1'b1);
        4: set_mode(4'd3, 4'd4, 1'b0, 1'b0);
        default: set_mode(4'($urandom_range(0, 15)), 4'($urandom_range(0, 8)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      random_phase(50);
      drain();
    end

    if (fail_count == 0)
      $display("tb_set_assoc_cache_lru_controller_top: clean");
    else
      $display("tb_set_assoc_cache_lru_controller_top: errors");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/sacl_pkg.sv
sv/sacl_front.sv
sv/sacl_back.sv
sv/set_assoc_cache_lru_controller_top.sv
tb/sacl_checker.sv
tb/tb_set_assoc_cache_lru_controller_top.sv
